>>> rtl/fdre_pkg.sv
// shared types and constants for the fractional divider register encoder
// used by fdre_cell, fdre_writer, the top level and the checker
package fdre_pkg;

    localparam int FracBits   = 20;
    localparam int FieldBits  = 20;
    localparam int ScaleShift = 7;
    localparam int DvdBits    = FieldBits + ScaleShift;
    localparam int P1Bits     = 18;
    localparam int CntBits    = 4;
    localparam int WritesPerReq = 9;

    localparam logic [CntBits-1:0] LastCnt = CntBits'(WritesPerReq - 1);
    localparam logic [P1Bits-1:0]  P1Offset = P1Bits'(512);

    localparam logic [9:0] PllIntMin = 10'd15;
    localparam logic [9:0] PllIntMax = 10'd90;
    localparam logic [9:0] MsIntMin  = 10'd4;
    localparam logic [9:0] MsIntMax  = 10'd900;
    localparam logic [1:0] OutIdxBad = 2'd3;

    localparam logic [7:0] PllABase     = 8'd26;
    localparam logic [7:0] PllBBase     = 8'd34;
    localparam logic [7:0] MsBase       = 8'd42;
    localparam logic [7:0] ClkCtrlBase  = 8'd16;
    localparam logic [7:0] ClkCtrlData  = 8'h0F;
    localparam logic [7:0] PllResetAddr = 8'd177;
    localparam logic [7:0] PllResetData = 8'((1 << 7) | (1 << 5));

    localparam logic ModePll = 1'b0;
    localparam logic ModeMs  = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic                 pll_select;
        logic [1:0]           output_index;
        logic [9:0]           integer_part;
        logic [FieldBits-1:0] numerator;
        logic [FieldBits-1:0] denominator;
    } req_t;

    typedef struct packed {
        logic [7:0] reg_address;
        logic [7:0] reg_data;
        logic       error;
        logic       last;
    } wr_t;

    typedef struct packed {
        logic                 err;
        logic                 mode;
        logic                 pll_select;
        logic [1:0]           output_index;
        logic [9:0]           integer_part;
        logic                 num_zero;
        logic [FieldBits-1:0] den;
        logic [FieldBits-1:0] rem;
        logic [DvdBits-1:0]   dq;
    } cell_t;

endpackage

>>> rtl/fractional_divider_register_encoder.sv
// an accepted request passes through the divider cells and the writer before its first write
// throughput: one write per cycle while wr_ready is high; a valid request gives 9 writes, a rejected one 1
// the request rate is set by the single write port; the 27-cell divider chain
// takes a new request every cycle while the writer has room
// reset clears the cell valid bits and the writer state; nothing else to clear
module fractional_divider_register_encoder
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  fdre_pkg::req_t req,
    output logic           wr_valid,
    input  logic           wr_ready,
    output fdre_pkg::wr_t  wr
);

    logic            chain_valid [0:fdre_pkg::DvdBits];
    fdre_pkg::cell_t chain_data  [0:fdre_pkg::DvdBits];
    logic            advance;
    logic            load;
    logic            bad;

    assign advance   = !chain_valid[fdre_pkg::DvdBits] || load;
    assign req_ready = advance;

    always_comb
    begin
        bad = (req.denominator == '0)
           || ((req.numerator >> fdre_pkg::FracBits) != '0)
           || ((req.denominator >> fdre_pkg::FracBits) != '0);
        if (req.mode == fdre_pkg::ModePll)
        begin
            if (req.integer_part < fdre_pkg::PllIntMin
                || req.integer_part > fdre_pkg::PllIntMax)
            begin
                bad = 1'b1;
            end
        end
        else
        begin
            if (req.integer_part < fdre_pkg::MsIntMin
                || req.integer_part > fdre_pkg::MsIntMax
                || req.output_index == fdre_pkg::OutIdxBad)
            begin
                bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        chain_valid[0]             = req_valid;
        chain_data[0].err          = bad;
        chain_data[0].mode         = req.mode;
        chain_data[0].pll_select   = req.pll_select;
        chain_data[0].output_index = req.output_index;
        chain_data[0].integer_part = req.integer_part;
        chain_data[0].num_zero     = (req.numerator == '0);
        chain_data[0].den          = req.denominator;
        chain_data[0].rem          = '0;
        chain_data[0].dq           = {req.numerator, {fdre_pkg::ScaleShift{1'b0}}};
    end

    for (genvar i = 0; i < fdre_pkg::DvdBits; i++)
    begin : g_cell
        fdre_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (chain_valid[i]),
            .prev       (chain_data[i]),
            .cur_valid  (chain_valid[i+1]),
            .cur        (chain_data[i+1])
        );
    end

    fdre_writer u_writer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (chain_valid[fdre_pkg::DvdBits]),
        .tail       (chain_data[fdre_pkg::DvdBits]),
        .load       (load),
        .wr_valid   (wr_valid),
        .wr_ready   (wr_ready),
        .wr         (wr)
    );

endmodule

>>> rtl/fdre_cell.sv
// one restoring division step of the divider chain
// depends on fdre_pkg
module fdre_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           prev_valid,
    input  fdre_pkg::cell_t prev,
    output logic           cur_valid,
    output fdre_pkg::cell_t cur
);

    logic [fdre_pkg::FieldBits:0]   trial;
    logic [fdre_pkg::FieldBits:0]   diff;
    logic                           fits;
    logic                           valid_reg;
    fdre_pkg::cell_t                data_reg;
    fdre_pkg::cell_t                data_next;

    always_comb
    begin
        trial = {prev.rem, prev.dq[fdre_pkg::DvdBits-1]};
        diff  = trial - {1'b0, prev.den};
        fits  = (trial >= {1'b0, prev.den});
        data_next     = prev;
        data_next.rem = fits ? diff[fdre_pkg::FieldBits-1:0]
                             : trial[fdre_pkg::FieldBits-1:0];
        data_next.dq  = {prev.dq[fdre_pkg::DvdBits-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign cur_valid = valid_reg;
    assign cur       = data_reg;

endmodule

>>> rtl/fdre_writer.sv
// packs divider results into parameter bytes and sends the register writes
// depends on fdre_pkg
module fdre_writer
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tail_valid,
    input  fdre_pkg::cell_t tail,
    output logic            load,
    output logic            wr_valid,
    input  logic            wr_ready,
    output fdre_pkg::wr_t   wr
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [fdre_pkg::CntBits-1:0]  cnt_reg;
    logic [fdre_pkg::CntBits-1:0]  cnt_next;
    logic                          err_reg;
    logic [fdre_pkg::P1Bits-1:0]   p1_reg;
    logic [fdre_pkg::FieldBits-1:0] p2_reg;
    logic [fdre_pkg::FieldBits-1:0] p3_reg;
    logic [7:0]                    base_reg;
    logic [7:0]                    close_addr_reg;
    logic [7:0]                    close_data_reg;
    logic [fdre_pkg::P1Bits-1:0]   p1_next;
    logic [7:0]                    base_next;
    logic [7:0]                    close_addr_next;
    logic [7:0]                    close_data_next;
    logic                          cur_last;
    logic                          done;
    logic [7:0]                    data_sel;

    assign cur_last = err_reg || (cnt_reg == fdre_pkg::LastCnt);
    assign done     = busy_reg && wr_ready && cur_last;
    assign load     = tail_valid && (!busy_reg || done);
    assign wr_valid = busy_reg;

    always_comb
    begin
        p1_next = {1'b0, tail.integer_part, 7'b0}
                + tail.dq[fdre_pkg::P1Bits-1:0] - fdre_pkg::P1Offset;
        if (tail.mode == fdre_pkg::ModePll)
        begin
            base_next       = tail.pll_select ? fdre_pkg::PllBBase : fdre_pkg::PllABase;
            close_addr_next = fdre_pkg::PllResetAddr;
            close_data_next = fdre_pkg::PllResetData;
        end
        else
        begin
            base_next       = fdre_pkg::MsBase + {3'b0, tail.output_index, 3'b0};
            close_addr_next = fdre_pkg::ClkCtrlBase + {6'b0, tail.output_index};
            close_data_next = fdre_pkg::ClkCtrlData
                            | {1'b0, tail.num_zero, tail.pll_select, 5'b0};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && wr_ready)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg        <= tail.err;
            p1_reg         <= p1_next;
            p2_reg         <= tail.rem;
            p3_reg         <= tail.den;
            base_reg       <= base_next;
            close_addr_reg <= close_addr_next;
            close_data_reg <= close_data_next;
        end
    end

    always_comb
    begin
        case (cnt_reg)
            4'd0:    data_sel = p3_reg[15:8];
            4'd1:    data_sel = p3_reg[7:0];
            4'd2:    data_sel = {6'b0, p1_reg[17:16]};
            4'd3:    data_sel = p1_reg[15:8];
            4'd4:    data_sel = p1_reg[7:0];
            4'd5:    data_sel = {p3_reg[19:16], p2_reg[19:16]};
            4'd6:    data_sel = p2_reg[15:8];
            4'd7:    data_sel = p2_reg[7:0];
            default: data_sel = close_data_reg;
        endcase
    end

    always_comb
    begin
        wr.error = err_reg;
        wr.last  = cur_last;
        if (err_reg)
        begin
            wr.reg_address = '0;
            wr.reg_data    = '0;
        end
        else if (cnt_reg == fdre_pkg::LastCnt)
        begin
            wr.reg_address = close_addr_reg;
            wr.reg_data    = data_sel;
        end
        else
        begin
            wr.reg_address = base_reg + {4'b0, cnt_reg};
            wr.reg_data    = data_sel;
        end
    end

endmodule

>>> rtl/fdre_checker.sv
// port-level checks for the fractional divider register encoder
// depends on fdre_pkg; bound to the top level below
module fdre_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input fdre_pkg::req_t req,
    input logic           wr_valid,
    input logic           wr_ready,
    input fdre_pkg::wr_t  wr
);

    a_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_ready |=> wr_valid && $stable(wr))
        else $error("write changed while stalled");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr.error |-> wr.last && wr.reg_address == '0 && wr.reg_data == '0)
        else $error("rejected request result malformed");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_ready && !wr.last |=> wr_valid && !wr.error)
        else $error("write run broken before last");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> wr_valid)
        else $error("request stalled with no pending write");

endmodule

bind fractional_divider_register_encoder fdre_checker u_fdre_checker (.*);

>>> tb/fractional_divider_register_encoder_tb.sv
`timescale 1ns / 1ps
// testbench for fractional_divider_register_encoder: random and directed setup requests,
// predicted register writes checked in order against the write channel
// depends on fdre_pkg and the rtl top level

module fractional_divider_register_encoder_tb;

    localparam int MaxCycles   = 200000;
    localparam int HoldCycles  = 400;
    localparam int DrainCycles = 60;
    localparam int MaxPrinted  = 50;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    fdre_pkg::req_t req = '0;
    logic wr_valid;
    logic wr_ready = 1'b0;
    fdre_pkg::wr_t  wr;

    fdre_pkg::req_t pending_reqs[$];
    fdre_pkg::wr_t  exp_writes[$];
    int   mismatches = 0;
    int   queued_cnt = 0;
    int   accepted_cnt = 0;
    int   cycle_cnt = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_left = 0;
    logic hold_start = 1'b0;

    fractional_divider_register_encoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr        (wr)
    );

    always #2 clk = ~clk;

    // expected register writes for one request
    function automatic void predict_writes(input fdre_pkg::req_t r);
        logic [31:0] scaled;
        logic [31:0] quot;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [19:0] p3;
        logic [7:0]  base;
        logic [7:0]  ctrl;
        logic [7:0]  bytes [8];
        logic        bad;
        fdre_pkg::wr_t w;
        bad = (r.denominator == '0);
        if (r.mode == fdre_pkg::ModePll)
            bad = bad || r.integer_part < fdre_pkg::PllIntMin
                || r.integer_part > fdre_pkg::PllIntMax;
        else
            bad = bad || r.integer_part < fdre_pkg::MsIntMin
                || r.integer_part > fdre_pkg::MsIntMax
                || r.output_index == fdre_pkg::OutIdxBad;
        if (bad)
        begin
            w.reg_address = 8'd0;
            w.reg_data    = 8'd0;
            w.error       = 1'b1;
            w.last        = 1'b1;
            exp_writes.push_back(w);
            return;
        end
        scaled = {5'd0, r.numerator, 7'd0};
        quot   = scaled / {12'd0, r.denominator};
        p2     = scaled % {12'd0, r.denominator};
        p3     = r.denominator;
        p1     = ({22'd0, r.integer_part} << 7) + quot - 32'd512;
        if (r.mode == fdre_pkg::ModePll)
            base = r.pll_select ? fdre_pkg::PllBBase : fdre_pkg::PllABase;
        else
            base = fdre_pkg::MsBase + {3'd0, r.output_index, 3'd0};
        bytes[0] = p3[15:8];
        bytes[1] = p3[7:0];
        bytes[2] = {6'd0, p1[17:16]};
        bytes[3] = p1[15:8];
        bytes[4] = p1[7:0];
        bytes[5] = {p3[19:16], p2[19:16]};
        bytes[6] = p2[15:8];
        bytes[7] = p2[7:0];
        for (int i = 0; i < 8; i++)
        begin
            w.reg_address = base + 8'(i);
            w.reg_data    = bytes[i];
            w.error       = 1'b0;
            w.last        = 1'b0;
            exp_writes.push_back(w);
        end
        if (r.mode == fdre_pkg::ModePll)
        begin
            w.reg_address = fdre_pkg::PllResetAddr;
            w.reg_data    = fdre_pkg::PllResetData;
        end
        else
        begin
            ctrl = fdre_pkg::ClkCtrlData;
            if (r.pll_select)
                ctrl[5] = 1'b1;
            if (r.numerator == '0)
                ctrl[6] = 1'b1;
            w.reg_address = fdre_pkg::ClkCtrlBase + {6'd0, r.output_index};
            w.reg_data    = ctrl;
        end
        w.last = 1'b1;
        exp_writes.push_back(w);
    endfunction

    function automatic fdre_pkg::req_t make_req(input logic mode, input logic pllb,
                                                input logic [1:0] outi, input logic [9:0] a,
                                                input logic [19:0] num,
                                                input logic [19:0] den);
        fdre_pkg::req_t r;
        r.mode         = mode;
        r.pll_select   = pllb;
        r.output_index = outi;
        r.integer_part = a;
        r.numerator    = num;
        r.denominator  = den;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MaxPrinted)
            $display("mismatch %s: got %0h expected %0h at cycle %0d",
                     what, got, want, cycle_cnt);
        mismatches++;
    endtask

    task automatic push_req(input fdre_pkg::req_t r);
        pending_reqs.push_back(r);
        queued_cnt++;
    endtask

    task automatic add_random(input int n);
        fdre_pkg::req_t r;
        int   kind;
        repeat (n)
        begin
            kind = $urandom_range(0, 99);
            r.mode         = 1'($urandom_range(0, 1));
            r.pll_select   = 1'($urandom_range(0, 1));
            if (kind < 12)
            begin
                // noise, mostly out of range
                r.output_index = 2'($urandom_range(0, 3));
                r.integer_part = 10'($urandom_range(0, 1023));
                r.numerator    = 20'($urandom_range(0, 20'hFFFFF));
                r.denominator  = ($urandom_range(0, 3) == 0)
                               ? 20'd0 : 20'($urandom_range(0, 20'hFFFFF));
            end
            else
            begin
                r.output_index = 2'($urandom_range(0, 2));
                r.integer_part = (r.mode == fdre_pkg::ModePll)
                               ? 10'($urandom_range(15, 90))
                               : 10'($urandom_range(4, 900));
                kind = $urandom_range(0, 7);
                if (kind < 2)
                    r.denominator = 20'($urandom_range(1, 16));
                else if (kind == 2)
                    r.denominator = 20'($urandom_range(20'hFFF00, 20'hFFFFF));
                else
                    r.denominator = 20'($urandom_range(1, 20'hFFFFF));
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    r.numerator = '0;
                else if (kind < 4)
                    r.numerator = 20'($urandom_range(0, r.denominator - 20'd1));
                else
                    r.numerator = 20'($urandom_range(0, 20'hFFFFF));
            end
            push_req(r);
        end
    endtask

    task automatic wait_drained;
        while (accepted_cnt != queued_cnt || exp_writes.size() != 0)
            @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                predict_writes(req);
                accepted_cnt++;
            end
            if (!req_valid || req_ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // write monitor
    always @(posedge clk or negedge rst_n)
    begin
        fdre_pkg::wr_t w_exp;
        if (!rst_n)
            wr_ready <= 1'b0;
        else
        begin
            if (wr_valid && wr_ready)
            begin
                if (exp_writes.size() == 0)
                    report_mismatch("unexpected write", {24'd0, wr.reg_address}, 32'd0);
                else
                begin
                    w_exp = exp_writes.pop_front();
                    if (wr.reg_address !== w_exp.reg_address)
                        report_mismatch("reg_address", 32'(wr.reg_address),
                                        32'(w_exp.reg_address));
                    if (wr.reg_data !== w_exp.reg_data)
                        report_mismatch("reg_data", 32'(wr.reg_data),
                                        32'(w_exp.reg_data));
                    if (wr.error !== w_exp.error)
                        report_mismatch("error", 32'(wr.error), 32'(w_exp.error));
                    if (wr.last !== w_exp.last)
                        report_mismatch("last", 32'(wr.last), 32'(w_exp.last));
                end
            end
            wr_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left  <= HoldCycles;
            hold_start <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MaxCycles)
        begin
            $display("FAIL fractional_divider_register_encoder");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 63;
        push_req(make_req(fdre_pkg::ModePll, 1'b0, 2'd0, 10'd15, 20'd0, 20'd1));
        push_req(make_req(fdre_pkg::ModePll, 1'b1, 2'd0, 10'd90, 20'hFFFFF, 20'hFFFFF));
        push_req(make_req(fdre_pkg::ModePll, 1'b0, 2'd1, 10'd14, 20'd5, 20'd7));
        push_req(make_req(fdre_pkg::ModePll, 1'b1, 2'd2, 10'd91, 20'd5, 20'd7));
        push_req(make_req(fdre_pkg::ModePll, 1'b0, 2'd0, 10'd50, 20'd5, 20'd0));
        push_req(make_req(fdre_pkg::ModePll, 1'b1, 2'd3, 10'd36, 20'd1, 20'd3));
        push_req(make_req(fdre_pkg::ModePll, 1'b0, 2'd0, 10'd15, 20'hFFFFF, 20'd1));
        push_req(make_req(fdre_pkg::ModePll, 1'b0, 2'd0, 10'd0, 20'd0, 20'd0));
        push_req(make_req(fdre_pkg::ModePll, 1'b1, 2'd1, 10'd90, 20'd1, 20'hFFFFF));
        push_req(make_req(fdre_pkg::ModeMs, 1'b0, 2'd0, 10'd4, 20'd0, 20'd1));
        push_req(make_req(fdre_pkg::ModeMs, 1'b1, 2'd1, 10'd900, 20'hFFFFF, 20'hFFFFF));
        push_req(make_req(fdre_pkg::ModeMs, 1'b1, 2'd2, 10'd4, 20'd0, 20'hFFFFF));
        push_req(make_req(fdre_pkg::ModeMs, 1'b0, 2'd2, 10'd900, 20'hFFFFF, 20'd1));
        push_req(make_req(fdre_pkg::ModeMs, 1'b0, 2'd0, 10'd3, 20'd9, 20'd10));
        push_req(make_req(fdre_pkg::ModeMs, 1'b1, 2'd1, 10'd901, 20'd9, 20'd10));
        push_req(make_req(fdre_pkg::ModeMs, 1'b0, 2'd3, 10'd100, 20'd9, 20'd10));
        push_req(make_req(fdre_pkg::ModeMs, 1'b1, 2'd2, 10'd100, 20'd9, 20'd0));
        push_req(make_req(fdre_pkg::ModeMs, 1'b1, 2'd3, 10'd1023, 20'hFFFFF, 20'hFFFFF));
        push_req(make_req(fdre_pkg::ModeMs, 1'b0, 2'd0, 10'd0, 20'd0, 20'd0));
        push_req(make_req(fdre_pkg::ModeMs, 1'b1, 2'd0, 10'd100, 20'd12345, 20'd54321));
        add_random(63);
        wait_drained();

        send_idle_pct = 63;
        recv_idle_pct = 12;
        add_random(83);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_start = 1'b1;
        add_random(84);
        wait_drained();

        repeat (DrainCycles) @(negedge clk);
        if (mismatches == 0)
            $display("PASS fractional_divider_register_encoder");
        else
            $display("FAIL fractional_divider_register_encoder");
        $finish;
    end

endmodule
